// ===== rtl/lpp_pkg.sv =====
// Shared types, widths and constants of the line position PID block.
`timescale 1ns / 1ps

package lpp_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 12;
  localparam int CAL_W      = 12;
  localparam int THR_W      = 10;
  localparam int POS_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DRIVE_W    = 24;

  // Internal state widths
  localparam int CH_W      = 4;
  localparam int NORM_W    = 10;
  localparam int WSUM_W    = 28;
  localparam int VSUM_W    = 14;
  localparam int ERR_W     = 17;
  localparam int DELTA_W   = 18;
  localparam int INTEG_W   = 12;
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int GAIN_FRAC = 8;

  // Shared divider widths
  localparam int DIV_NUM_W = WSUM_W;
  localparam int DIV_DEN_W = VSUM_W;

  // Arithmetic constants
  localparam int NORM_FULL       = 1000;
  localparam int DIV10_RECIP     = 52429;
  localparam int DIV10_SHIFT     = 19;
  localparam int INTEG_LIMIT_MAX = 2047;

  // Parameter defaults
  localparam int DEF_SENSOR_COUNT = 16;
  localparam int DEF_SAMPLE_BITS  = 12;

  typedef enum logic [1:0] {
    MODE_BIN_BLACK = 2'd0,
    MODE_BIN_WHITE = 2'd1,
    MODE_MAP_BLACK = 2'd2,
    MODE_MAP_WHITE = 2'd3
  } line_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_MIN   = 3'd0,
    REG_CAL_MAX   = 3'd1,
    REG_LINE_MODE = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_TARGET    = 3'd4,
    REG_GAIN_P    = 3'd5,
    REG_GAIN_I    = 3'd6,
    REG_GAIN_D    = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_RMUL,
    S_RDIV_GO,
    S_RDIV_WAIT,
    S_ACC1,
    S_ACC2,
    S_ACC3,
    S_POS,
    S_CDIV,
    S_LIM,
    S_ERR,
    S_MP,
    S_MI,
    S_MD,
    S_SUM,
    S_OUT
  } state_t;

endpackage

// ===== rtl/lpp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by remap and centroid.
`timescale 1ns / 1ps

module lpp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lpp_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [lpp_pkg::DIV_DEN_W-1:0] divisor,
  output logic                         done,
  output logic [lpp_pkg::DIV_NUM_W-1:0] quotient
);
  import lpp_pkg::*;

  localparam int CntW = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CntW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Flag the cycle after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == CntW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift the dividend out and the quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/line_position_pid_top.sv =====
// Top level: sample normaliser, centroid accumulator and PID under one sequencer.
//
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid/in_ready    in_sample[11:0], in_frame_end
//  out_     output     out_valid/out_ready  out_drive[23:0] signed, out_line_lost
//  cfg_     input      cfg_we               cfg_index[2:0], cfg_wdata[15:0]
//
// A binarised sample skips the divider; a remapped sample takes a pass of the
// 28-step divider. A frame-end sample adds a divider pass for the centroid if a
// line was seen, then the shared 17x18 multiplier runs the limit and the three
// PID terms. Reset is synchronous, active low, and clears all but the datapath
// registers. in_ready is high only while the sequencer is idle; a result waiting
// in the output register does not block new samples until the next frame end.
`timescale 1ns / 1ps

module line_position_pid_top #(
  parameter int SENSOR_COUNT = lpp_pkg::DEF_SENSOR_COUNT,
  parameter int SAMPLE_BITS  = lpp_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lpp_pkg::SAMPLE_W-1:0]          in_sample,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lpp_pkg::DRIVE_W-1:0]    out_drive,
  output logic                                 out_line_lost,
  input  logic                                 cfg_we,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import lpp_pkg::*;

  localparam logic [SAMPLE_W-1:0] SampleMask =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [CH_W-1:0]  ChLast   = CH_W'(SENSOR_COUNT - 1);
  localparam logic [POS_W-1:0] LostHigh = POS_W'((SENSOR_COUNT + 1) * NORM_FULL);
  localparam logic [NORM_W-1:0] NormFull = NORM_W'(NORM_FULL);
  localparam logic [POS_W-1:0] PosMax   = {POS_W{1'b1}};
  localparam logic [INTEG_W-1:0] LimMax = INTEG_W'(INTEG_LIMIT_MAX);
  localparam logic signed [SUM_W-1:0] DriveHi = SUM_W'((64'sd1 <<< (DRIVE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] DriveLo = -DriveHi - SUM_W'(1);

  // Configuration registers
  logic [CAL_W-1:0]         cal_min_r;
  logic [CAL_W-1:0]         cal_max_r;
  line_mode_t               line_mode_r;
  logic [THR_W-1:0]         thr_r;
  logic [POS_W-1:0]         target_r;
  logic signed [GAIN_W-1:0] gain_p_r;
  logic signed [GAIN_W-1:0] gain_i_r;
  logic signed [GAIN_W-1:0] gain_d_r;

  // Sequencer and datapath registers
  state_t                    state_r, state_nxt;
  logic [SAMPLE_W-1:0]       x_r;
  logic                      frame_end_r;
  logic [CAL_W-1:0]          xc_r;
  logic [NORM_W-1:0]         v_r;
  logic [CH_W-1:0]           ch_r;
  logic [WSUM_W-1:0]         wsum_r;
  logic [VSUM_W-1:0]         vsum_r;
  logic                      seen_r;
  logic [POS_W-1:0]          last_pos_r;
  logic [POS_W-1:0]          pos_r;
  logic                      lost_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_lost_r;

  // Combinational signals
  logic                      in_xfer;
  logic                      out_load;
  logic [CAL_W-1:0]          xc;
  logic [CAL_W-1:0]          mid;
  logic [CAL_W-1:0]          span;
  logic                      span_pos;
  logic [NORM_W-1:0]         bin_v;
  logic [NORM_W-1:0]         map_r;
  logic [NORM_W-1:0]         map_v;
  logic [POS_W-1:0]          cent;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;
  logic                      div_start;
  logic [DIV_NUM_W-1:0]      div_dividend;
  logic [DIV_DEN_W-1:0]      div_divisor;
  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_quot;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [DELTA_W-1:0] delta_c;
  logic signed [DELTA_W-1:0] acc_raw;
  logic signed [DELTA_W-1:0] acc_c;
  logic signed [DELTA_W-1:0] lim_s;
  logic [INTEG_W-1:0]        lim_q;
  logic [INTEG_W-1:0]        lim;
  logic signed [SUM_W-1:0]   sum_shift;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_min_r   <= '0;
      cal_max_r   <= {CAL_W{1'b1}};
      line_mode_r <= MODE_BIN_BLACK;
      thr_r       <= THR_W'(500);
      target_r    <= POS_W'(8500);
      gain_p_r    <= GAIN_W'(256);
      gain_i_r    <= '0;
      gain_d_r    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAL_MIN:   cal_min_r   <= cfg_wdata[CAL_W-1:0];
        REG_CAL_MAX:   cal_max_r   <= cfg_wdata[CAL_W-1:0];
        REG_LINE_MODE: line_mode_r <= line_mode_t'(cfg_wdata[1:0]);
        REG_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        REG_TARGET:    target_r    <= cfg_wdata[POS_W-1:0];
        REG_GAIN_P:    gain_p_r    <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_GAIN_I:    gain_i_r    <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_GAIN_D:    gain_d_r    <= $signed(cfg_wdata[GAIN_W-1:0]);
      endcase
    end
  end

  // Clamp to the calibration window, ceiling first
  always_comb begin
    if (x_r > cal_max_r) begin
      xc = cal_max_r;
    end else if (x_r < cal_min_r) begin
      xc = cal_min_r;
    end else begin
      xc = x_r;
    end
  end

  assign mid      = CAL_W'(({1'b0, cal_min_r} + {1'b0, cal_max_r}) >> 1);
  assign span     = cal_max_r - cal_min_r;
  assign span_pos = (cal_max_r > cal_min_r);

  // Binarise at the midpoint
  always_comb begin
    if (line_mode_r == MODE_BIN_BLACK) begin
      bin_v = (xc < mid) ? '0 : NormFull;
    end else begin
      bin_v = (xc > mid) ? '0 : NormFull;
    end
  end

  // Remap result from the divider, inverted for a white line
  assign map_r = (div_quot > DIV_NUM_W'(NORM_FULL)) ? NormFull : div_quot[NORM_W-1:0];
  assign map_v = (line_mode_r == MODE_MAP_BLACK) ? map_r : NormFull - map_r;

  // Centroid, saturated to the position width
  assign cent = (|div_quot[DIV_NUM_W-1:POS_W]) ? PosMax : div_quot[POS_W-1:0];

  // Error, derivative and clamped integrator
  assign err_c   = $signed({2'b00, pos_r}) - $signed({2'b00, target_r});
  assign delta_c = DELTA_W'(err_c) - DELTA_W'(prev_err_r);
  assign acc_raw = DELTA_W'(integ_r) + DELTA_W'(err_c);
  assign lim_q   = prod_r[DIV10_SHIFT +: INTEG_W];
  assign lim     = (lim_q > LimMax) ? LimMax : lim_q;
  assign lim_s   = $signed({{(DELTA_W - INTEG_W){1'b0}}, lim});

  always_comb begin
    if (acc_raw > lim_s) begin
      acc_c = lim_s;
    end else if (acc_raw < -lim_s) begin
      acc_c = -lim_s;
    end else begin
      acc_c = acc_raw;
    end
  end

  // Floor shift of the PID sum and saturation
  assign sum_shift = sum_r >>> GAIN_FRAC;

  always_comb begin
    if (sum_shift > DriveHi) begin
      drive_sat = DriveHi[DRIVE_W-1:0];
    end else if (sum_shift < DriveLo) begin
      drive_sat = DriveLo[DRIVE_W-1:0];
    end else begin
      drive_sat = sum_shift[DRIVE_W-1:0];
    end
  end

  // Shared multiplier
  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_NORM;
      end
      S_NORM: begin
        if ((line_mode_r == MODE_MAP_BLACK || line_mode_r == MODE_MAP_WHITE) && span_pos) begin
          state_nxt = S_RMUL;
        end else begin
          state_nxt = S_ACC1;
        end
      end
      S_RMUL:      state_nxt = S_RDIV_GO;
      S_RDIV_GO:   state_nxt = S_RDIV_WAIT;
      S_RDIV_WAIT: begin
        if (div_done) state_nxt = S_ACC1;
      end
      S_ACC1:      state_nxt = S_ACC2;
      S_ACC2:      state_nxt = S_ACC3;
      S_ACC3:      state_nxt = frame_end_r ? S_POS : S_IDLE;
      S_POS: begin
        if (seen_r && (vsum_r != '0)) begin
          state_nxt = S_CDIV;
        end else begin
          state_nxt = S_LIM;
        end
      end
      S_CDIV: begin
        if (div_done) state_nxt = S_LIM;
      end
      S_LIM:       state_nxt = S_ERR;
      S_ERR:       state_nxt = S_MP;
      S_MP:        state_nxt = S_MI;
      S_MI:        state_nxt = S_MD;
      S_MD:        state_nxt = S_SUM;
      S_SUM:       state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: multiplier operands and divider start
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    mul_en       = 1'b0;
    div_start    = 1'b0;
    div_dividend = prod_r[DIV_NUM_W-1:0];
    div_divisor  = {{(DIV_DEN_W - CAL_W){1'b0}}, span};
    unique case (state_r)
      S_RMUL: begin
        mul_a  = $signed(MUL_A_W'(xc_r - cal_min_r));
        mul_b  = MUL_B_W'(NORM_FULL);
        mul_en = 1'b1;
      end
      S_RDIV_GO: begin
        div_start = 1'b1;
      end
      S_ACC1: begin
        mul_a  = $signed(MUL_A_W'(v_r));
        mul_b  = $signed(MUL_B_W'({1'b0, ch_r} + 5'd1));
        mul_en = 1'b1;
      end
      S_ACC2: begin
        mul_a  = prod_r[MUL_A_W-1:0];
        mul_b  = MUL_B_W'(NORM_FULL);
        mul_en = 1'b1;
      end
      S_POS: begin
        div_start    = seen_r && (vsum_r != '0);
        div_dividend = wsum_r;
        div_divisor  = vsum_r;
      end
      S_LIM: begin
        mul_a  = $signed(MUL_A_W'(target_r));
        mul_b  = MUL_B_W'(DIV10_RECIP);
        mul_en = 1'b1;
      end
      S_MP: begin
        mul_a  = MUL_A_W'(gain_p_r);
        mul_b  = MUL_B_W'(err_r);
        mul_en = 1'b1;
      end
      S_MI: begin
        mul_a  = MUL_A_W'(gain_i_r);
        mul_b  = MUL_B_W'(integ_r);
        mul_en = 1'b1;
      end
      S_MD: begin
        mul_a  = MUL_A_W'(gain_d_r);
        mul_b  = delta_r;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  lpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // State register and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      wsum_r      <= '0;
      vsum_r      <= '0;
      seen_r      <= 1'b0;
      last_pos_r  <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Accumulate one channel
      if (state_r == S_ACC3) begin
        if (v_r >= thr_r) begin
          seen_r <= 1'b1;
          wsum_r <= wsum_r + prod_r[WSUM_W-1:0];
        end
        vsum_r <= vsum_r + VSUM_W'(v_r);
        ch_r   <= (ch_r == ChLast) ? '0 : ch_r + CH_W'(1);
      end

      // Keep the last good position
      if (state_r == S_POS && seen_r && vsum_r == '0) begin
        last_pos_r <= '0;
      end
      if (state_r == S_CDIV && div_done) begin
        last_pos_r <= cent;
      end

      // Advance the controller memory
      if (state_r == S_ERR) begin
        integ_r    <= INTEG_W'(acc_c);
        prev_err_r <= err_c;
      end

      // Hand the result over and drop the frame accumulators
      if (out_load) begin
        out_valid_r <= 1'b1;
        ch_r        <= '0;
        wsum_r      <= '0;
        vsum_r      <= '0;
        seen_r      <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r         <= in_sample & SampleMask;
      frame_end_r <= in_frame_end;
    end

    if (mul_en) begin
      prod_r <= mul_p;
    end

    if (state_r == S_NORM) begin
      xc_r <= xc;
      if (line_mode_r == MODE_BIN_BLACK || line_mode_r == MODE_BIN_WHITE) begin
        v_r <= bin_v;
      end else if (!span_pos) begin
        v_r <= (line_mode_r == MODE_MAP_BLACK) ? '0 : NormFull;
      end
    end

    if (state_r == S_RDIV_WAIT && div_done) begin
      v_r <= map_v;
    end

    // Position at frame end
    if (state_r == S_POS) begin
      lost_r <= !seen_r;
      if (!seen_r) begin
        pos_r <= (last_pos_r < target_r) ? '0 : LostHigh;
      end else begin
        pos_r <= '0;
      end
    end
    if (state_r == S_CDIV && div_done) begin
      pos_r <= cent;
    end

    if (state_r == S_ERR) begin
      err_r   <= err_c;
      delta_r <= delta_c;
    end

    // Sum the PID terms
    if (state_r == S_MI) begin
      sum_r <= SUM_W'(prod_r);
    end
    if (state_r == S_MD || state_r == S_SUM) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end

    if (out_load) begin
      out_drive_r <= drive_sat;
      out_lost_r  <= lost_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_line_lost = out_lost_r;

endmodule

// ===== tb/tb_line_position_pid_top.sv =====
// Self-checking testbench for the line position PID block: directed and random sensor frames.
`timescale 1ns / 1ps

module tb_line_position_pid_top;
  import lpp_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 750;
  localparam int IDLE_PERCENT  = 33;
  localparam int INTEG_DIVISOR = 10;
  localparam int POS_SAT       = 2 ** POS_W - 1;
  localparam int LOST_FAR      = (DEF_SENSOR_COUNT + 1) * NORM_FULL;
  localparam longint DRIVE_MAX = 2 ** (DRIVE_W - 1) - 1;
  localparam longint DRIVE_MIN = -(2 ** (DRIVE_W - 1));

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } sensor_sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      line_lost;
  } frame_result_t;

  // DUT ports, inputs all known from time zero
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [SAMPLE_W-1:0]          in_sample = '0;
  logic                         in_frame_end = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [DRIVE_W-1:0]    out_drive;
  logic                         out_line_lost;
  logic                         cfg_we = 1'b0;
  reg_idx_t                     cfg_index = REG_CAL_MIN;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;

  // Stimulus and expected results
  sensor_sample_t sample_queue[$];
  frame_result_t  drive_due[$];
  int  items_queued = 0;
  int  items_accepted = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  frames_seen = 0;
  int  lost_seen = 0;
  int  saturated_seen = 0;
  int  settings_used = 1;
  bit  no_gaps = 1'b0;

  // Register mirror, at reset values
  logic [CAL_W-1:0]         cal_lo = '0;
  logic [CAL_W-1:0]         cal_hi = 12'd4095;
  line_mode_t               mode_cfg = MODE_BIN_BLACK;
  logic [THR_W-1:0]         thr_cfg = 10'd500;
  logic [POS_W-1:0]         target_cfg = 15'd8500;
  logic signed [GAIN_W-1:0] kp = 16'sd256;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;

  // Frame accumulators and PID history
  logic [CH_W-1:0]   chan_idx = '0;
  logic [WSUM_W-1:0] wsum = '0;
  logic [VSUM_W-1:0] vsum = '0;
  logic              line_seen = 1'b0;
  logic [POS_W-1:0]  last_pos = '0;
  int                integ = 0;
  int                prev_err = 0;

  line_position_pid_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_line_lost (out_line_lost),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clamp to the calibration window, then binarise or remap to 0..1000
  function automatic int unsigned sensor_level(logic [SAMPLE_W-1:0] raw);
    int unsigned x, mid, r;
    x = raw;
    if (x > cal_hi) x = cal_hi;
    else if (x < cal_lo) x = cal_lo;
    mid = (32'(cal_lo) + 32'(cal_hi)) / 2;
    r = 0;
    case (mode_cfg)
      MODE_BIN_BLACK: r = (x < mid) ? 0 : NORM_FULL;
      MODE_BIN_WHITE: r = (x > mid) ? 0 : NORM_FULL;
      default: begin
        if (cal_hi > cal_lo) r = ((x - 32'(cal_lo)) * NORM_FULL) / (32'(cal_hi) - 32'(cal_lo));
        if (r > NORM_FULL) r = NORM_FULL;
        if (mode_cfg == MODE_MAP_WHITE) r = NORM_FULL - r;
      end
    endcase
    return r;
  endfunction

  // Accumulate one sample; on frame end work out position, PID and the expected drive
  task automatic predict_sample(logic [SAMPLE_W-1:0] raw, logic last);
    int unsigned   level, pos, lim;
    int            err, delta, acc;
    longint        pid_sum, scaled;
    frame_result_t res;
    level = sensor_level(raw);
    if (level >= thr_cfg) begin
      line_seen = 1'b1;
      wsum = WSUM_W'(wsum + level * (32'(chan_idx) + 1) * NORM_FULL);
    end
    vsum = VSUM_W'(vsum + level);
    chan_idx = chan_idx + 1'b1;
    if (last) begin
      if (!line_seen) begin
        res.line_lost = 1'b1;
        pos = (last_pos < target_cfg) ? 0 : LOST_FAR;
      end else begin
        res.line_lost = 1'b0;
        pos = (vsum == 0) ? 0 : wsum / vsum;
        if (pos > POS_SAT) pos = POS_SAT;
        last_pos = POS_W'(pos);
      end
      err = int'(pos) - int'(target_cfg);
      delta = err - prev_err;
      lim = target_cfg / INTEG_DIVISOR;
      if (lim > INTEG_LIMIT_MAX) lim = INTEG_LIMIT_MAX;
      acc = integ + err;
      if (acc > int'(lim)) acc = lim;
      else if (acc < -int'(lim)) acc = -int'(lim);
      integ = acc;
      prev_err = err;
      pid_sum = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * delta;
      scaled = pid_sum >>> GAIN_FRAC;
      if (scaled > DRIVE_MAX) scaled = DRIVE_MAX;
      if (scaled < DRIVE_MIN) scaled = DRIVE_MIN;
      if (scaled == DRIVE_MAX || scaled == DRIVE_MIN) saturated_seen++;
      res.drive = scaled[DRIVE_W-1:0];
      drive_due.push_back(res);
      frames_seen++;
      if (res.line_lost) lost_seen++;
      chan_idx = '0;
      wsum = '0;
      vsum = '0;
      line_seen = 1'b0;
    end
  endtask

  // Input driver: present queued samples, idling at random between transfers
  always @(posedge clk) begin : sample_driver
    sensor_sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample(in_sample, in_frame_end);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
          nxt = sample_queue.pop_front();
          in_valid     <= 1'b1;
          in_sample    <= nxt.sample;
          in_frame_end <= nxt.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expected drive
  always @(posedge clk) begin : result_monitor
    frame_result_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_due.size() == 0) begin
          $error("unexpected result transfer: drive %0d, line_lost %0b",
                 out_drive, out_line_lost);
          fail_count++;
        end else begin
          due = drive_due.pop_front();
          if (out_drive !== due.drive) begin
            $error("drive: expected %0d, actual %0d", due.drive, out_drive);
            fail_count++;
          end
          if (out_line_lost !== due.line_lost) begin
            $error("line_lost: expected %0b, actual %0b", due.line_lost, out_line_lost);
            fail_count++;
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Write one register while the block is idle and update the mirror
  task automatic write_reg(reg_idx_t idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_CAL_MIN:   cal_lo = data[CAL_W-1:0];
      REG_CAL_MAX:   cal_hi = data[CAL_W-1:0];
      REG_LINE_MODE: mode_cfg = line_mode_t'(data[1:0]);
      REG_THRESHOLD: thr_cfg = data[THR_W-1:0];
      REG_TARGET:    target_cfg = data[POS_W-1:0];
      REG_GAIN_P:    kp = signed'(data);
      REG_GAIN_I:    ki = signed'(data);
      REG_GAIN_D:    kd = signed'(data);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] raw, logic last);
    sensor_sample_t item;
    item.sample = raw;
    item.frame_end = last;
    sample_queue.push_back(item);
    items_queued++;
  endtask

  // Hold until every sample has transferred and every result has arrived
  task automatic settle();
    while (items_accepted != items_queued || drive_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int frame_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1, 15);
    if (r < 18) return $urandom_range(17, 40);
    return DEF_SENSOR_COUNT;
  endfunction

  // A frame with a line of a few channels over a background, or plain noise
  task automatic queue_frame(int len);
    int centre, width, style;
    logic [SAMPLE_W-1:0] on_level, off_level, swap, raw;
    style = $urandom_range(9);
    centre = $urandom_range(len - 1);
    width = $urandom_range(2);
    if (style < 5) begin
      on_level = $urandom_range(3600, 4095);
      off_level = $urandom_range(500);
      if (mode_cfg == MODE_BIN_WHITE || mode_cfg == MODE_MAP_WHITE) begin
        swap = on_level;
        on_level = off_level;
        off_level = swap;
      end
    end else begin
      on_level = $urandom_range(4095);
      off_level = $urandom_range(4095);
    end
    for (int i = 0; i < len; i++) begin
      if (style == 9) raw = $urandom_range(4095);
      else if (i >= centre - width && i <= centre + width)
        raw = on_level ^ SAMPLE_W'($urandom_range(63));
      else raw = off_level ^ SAMPLE_W'($urandom_range(63));
      push_sample(raw, i == len - 1);
    end
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(9);
    if (r < 2) return $urandom_range(1) ? 32767 : -32768;
    if (r < 5) return $urandom_range(65535);
    return int'($urandom_range(1024)) - 512;
  endfunction

  // Draw a fresh register setting, extremes included
  task automatic pick_setting();
    int r, lo, hi, thr, tgt;
    r = $urandom_range(9);
    if (r == 0) begin
      lo = 0;
      hi = 4095;
    end else if (r == 1) begin
      hi = $urandom_range(4095);
      lo = $urandom_range(hi, 4095);
    end else begin
      lo = $urandom_range(1500);
      hi = $urandom_range(2500, 4095);
    end
    r = $urandom_range(9);
    thr = (r == 0) ? 1 : (r == 1) ? NORM_FULL : $urandom_range(100, 900);
    r = $urandom_range(9);
    tgt = (r == 0) ? 0 : (r == 1) ? LOST_FAR : $urandom_range(LOST_FAR);
    write_reg(REG_CAL_MIN, lo);
    write_reg(REG_CAL_MAX, hi);
    write_reg(REG_LINE_MODE, $urandom_range(3));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    settings_used++;
  endtask

  initial begin : stimulus
    int phase, frames, directed_items;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: binarise black around the midpoint, then a frame with no line
    push_sample(12'd0, 1'b0);
    push_sample(12'd4095, 1'b0);
    push_sample(12'd2047, 1'b0);
    push_sample(12'd2046, 1'b1);
    push_sample(12'd0, 1'b1);
    settle();

    // Binarise white, clamp above the ceiling, sample on the midpoint
    write_reg(REG_LINE_MODE, MODE_BIN_WHITE);
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_CAL_MIN, 1000);
    write_reg(REG_CAL_MAX, 3000);
    push_sample(12'd4095, 1'b0);
    push_sample(12'd2000, 1'b1);
    settle();

    // Inverted window, zero threshold: line seen with zero plain sum
    write_reg(REG_CAL_MIN, 3000);
    write_reg(REG_CAL_MAX, 1000);
    write_reg(REG_LINE_MODE, MODE_MAP_BLACK);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_TARGET, 0);
    push_sample(12'd2000, 1'b1);
    settle();

    // Unreachable threshold: line lost with last position at or past the target
    write_reg(REG_THRESHOLD, 1023);
    push_sample(12'd4095, 1'b1);
    settle();

    // Remap white with clamp below the floor, threshold at full scale
    write_reg(REG_CAL_MIN, 100);
    write_reg(REG_CAL_MAX, 3100);
    write_reg(REG_LINE_MODE, MODE_MAP_WHITE);
    write_reg(REG_THRESHOLD, NORM_FULL);
    push_sample(12'd50, 1'b0);
    push_sample(12'd4095, 1'b0);
    push_sample(12'd1600, 1'b1);
    settle();

    // Full gains, far target: line lost below target, integrator pinned
    write_reg(REG_CAL_MIN, 0);
    write_reg(REG_CAL_MAX, 4095);
    write_reg(REG_LINE_MODE, MODE_MAP_BLACK);
    write_reg(REG_THRESHOLD, 1);
    write_reg(REG_TARGET, 32767);
    write_reg(REG_GAIN_P, 32767);
    write_reg(REG_GAIN_I, 32767);
    write_reg(REG_GAIN_D, 32767);
    push_sample(12'd0, 1'b1);
    settle();

    // Overlong frame: channel wrap, sum wrap, centroid and drive saturate high
    write_reg(REG_TARGET, 0);
    for (int i = 0; i <= DEF_SENSOR_COUNT; i++) push_sample(12'd4095, i == DEF_SENSOR_COUNT);
    settle();

    // Swing back to the far target so the drive saturates low
    write_reg(REG_TARGET, 32767);
    push_sample(12'd0, 1'b1);
    settle();
    settings_used += 7;
    directed_items = items_queued;

    // Random settings, each with a batch of frames; one batch without gaps
    while (items_queued < directed_items + RANDOM_ITEMS) begin
      pick_setting();
      no_gaps = (phase == 2);
      frames = $urandom_range(4, 9);
      repeat (frames) queue_frame(frame_length());
      settle();
      no_gaps = 1'b0;
      phase++;
    end

    $display("Covered %0d samples in %0d frames under %0d register settings;",
             items_accepted, frames_seen, settings_used);
    $display("%0d frames lost the line and %0d drives hit a saturation limit.",
             lost_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
